// File: rtl/circular_byte_fifo_with_peek_unit_macros.svh
// Assertion helpers shared by the FIFO modules. Both expect clk_i and rst_ni
// in the scope where they are used.
`ifndef CIRCULAR_BYTE_FIFO_WITH_PEEK_UNIT_MACROS_SVH
`define CIRCULAR_BYTE_FIFO_WITH_PEEK_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CBF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CBF_ASSERT(label, prop, msg)
`define CBF_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: rtl/cbf_pkg.sv
package cbf_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned SW    = CW + 1;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_DISCARD = 2'd2,
    FUNC_PEEK    = 2'd3
  } cbf_func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } cbf_status_e;

  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } cbf_state_e;

  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] addr;
    logic [7:0]    wdata;
  } cbf_mem_req_t;

  typedef struct packed {
    cbf_status_e   status;
    logic [AW-1:0] first_offset;
    logic [CW-1:0] first_length;
    logic [CW-1:0] second_length;
    logic [CW-1:0] fill_level;
  } cbf_res_t;

endpackage

// File: rtl/cbf_ram.sv
module cbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cbf_ptr.sv
`include "circular_byte_fifo_with_peek_unit_macros.svh"

module cbf_ptr import cbf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         apply_i,
  input  cbf_func_e    func_i,
  input  logic [7:0]   data_in_i,
  input  logic [CW-1:0] count_i,
  output cbf_mem_req_t mem_req_o,
  output cbf_res_t     res_o
);

  logic [AW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [CW-1:0] fill_q, fill_d;

  logic [AW-1:0] rp_inc, wp_inc;
  logic [SW-1:0] disc_sum, peek_sum, chk_sum;
  logic [AW-1:0] disc_rp, wp_expect;
  logic [CW-1:0] peek_m, len1, len2;
  logic          full, empty;

  assign full  = (fill_q == CW'(DEPTH));
  assign empty = (fill_q == '0);

  assign rp_inc = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
  assign wp_inc = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);

  // The read pointer plus at most DEPTH stays below twice DEPTH, so one
  // subtraction wraps it.
  assign disc_sum = SW'(rp_q) + SW'(count_i);
  assign disc_rp  = (disc_sum >= SW'(DEPTH)) ? AW'(disc_sum - SW'(DEPTH)) : AW'(disc_sum);

  assign peek_m   = (count_i < fill_q) ? count_i : fill_q;
  assign peek_sum = SW'(rp_q) + SW'(peek_m);

  always_comb begin
    if (peek_sum > SW'(DEPTH)) begin
      len1 = CW'(DEPTH) - CW'(rp_q);
      len2 = peek_m - len1;
    end else begin
      len1 = peek_m;
      len2 = '0;
    end
  end

  always_comb begin
    rp_d      = rp_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    mem_req_o = '{we: 1'b0, re: 1'b0, addr: rp_q, wdata: data_in_i};
    res_o.status        = STATUS_OK;
    res_o.first_length  = '0;
    res_o.second_length = '0;
    case (func_i)
      FUNC_PUSH: begin
        mem_req_o.addr = wp_q;
        if (full) begin
          res_o.status = STATUS_OVERFLOW;
        end else begin
          mem_req_o.we = apply_i;
          wp_d   = wp_inc;
          fill_d = fill_q + CW'(1);
        end
      end
      FUNC_POP: begin
        if (empty) begin
          res_o.status = STATUS_UNDERFLOW;
        end else begin
          mem_req_o.re = apply_i;
          rp_d   = rp_inc;
          fill_d = fill_q - CW'(1);
        end
      end
      FUNC_DISCARD: begin
        if (count_i > fill_q) begin
          res_o.status = STATUS_UNDERFLOW;
        end else begin
          rp_d   = disc_rp;
          fill_d = fill_q - count_i;
        end
      end
      default: begin
        res_o.first_length  = len1;
        res_o.second_length = len2;
      end
    endcase
    res_o.first_offset = rp_d;
    res_o.fill_level   = fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      wp_q   <= '0;
      fill_q <= '0;
    end else if (apply_i) begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

  // The write pointer always sits fill_q entries past the read pointer.
  assign chk_sum   = SW'(rp_q) + SW'(fill_q);
  assign wp_expect = (chk_sum >= SW'(DEPTH)) ? AW'(chk_sum - SW'(DEPTH)) : AW'(chk_sum);

  `CBF_ASSERT_NEVER(a_fill_bound, fill_q > CW'(DEPTH), "fill count beyond depth")
  `CBF_ASSERT_NEVER(a_ptr_consistent, wp_q != wp_expect, "pointers disagree with fill")
  `CBF_ASSERT(a_push_fill, apply_i && func_i == FUNC_PUSH && !full |=> fill_q == $past(fill_q) + CW'(1), "push did not grow fill")
  `CBF_ASSERT_NEVER(a_mem_excl, mem_req_o.we && mem_req_o.re, "read and write in one cycle")

endmodule

// File: rtl/circular_byte_fifo_with_peek_unit.sv
// Byte ring buffer of cbf_pkg::DEPTH entries with push, pop, discard and
// peek-max. One operation is accepted per cycle unless input is held off;
// push, discard, peek-max and a refused pop produce their result in the
// output register in the cycle after acceptance and the input is ready again
// at once, while a successful pop must wait for its byte from the single-port
// storage RAM, which has a registered read, and input is held off meanwhile.
// The input also waits while a result sits unclaimed in the output register.
// Bytes that were never pushed are not initialized; there is no clearing
// pass, so the block is ready right after reset.
`include "circular_byte_fifo_with_peek_unit_macros.svh"

module circular_byte_fifo_with_peek_unit import cbf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    func_i,
  input  logic [7:0]    data_in_i,
  input  logic [CW-1:0] count_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    data_out_o,
  output logic [1:0]    status_o,
  output logic [AW-1:0] first_offset_o,
  output logic [CW-1:0] first_length_o,
  output logic [CW-1:0] second_length_o,
  output logic [CW-1:0] fill_level_o
);

  cbf_state_e   state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         accept;
  cbf_mem_req_t mem_req;
  cbf_res_t     res, res_q;
  logic [7:0]   rdata, data_q;

  cbf_ptr u_ptr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .apply_i   (accept),
    .func_i    (cbf_func_e'(func_i)),
    .data_in_i (data_in_i),
    .count_i   (count_i),
    .mem_req_o (mem_req),
    .res_o     (res)
  );

  cbf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && mem_req.re) begin
          state_d = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE:     in_ready_o = !out_valid_q || out_ready_i;
      ST_POP_WAIT: in_ready_o = 1'b0;
      default:     in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // A successful pop holds its result back until the RAM byte arrives.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = !mem_req.re;
    end else if (state_q == ST_POP_WAIT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= res;
      data_q <= '0;
    end else if (state_q == ST_POP_WAIT) begin
      data_q <= rdata;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_out_o      = data_q;
  assign status_o        = res_q.status;
  assign first_offset_o  = res_q.first_offset;
  assign first_length_o  = res_q.first_length;
  assign second_length_o = res_q.second_length;
  assign fill_level_o    = res_q.fill_level;

  `CBF_ASSERT(a_pop_result, state_q == ST_POP_WAIT |=> out_valid_q, "pop result not presented")
  `CBF_ASSERT_NEVER(a_pop_blocks, state_q == ST_POP_WAIT && (out_valid_q || in_ready_o), "pop wait overlaps a beat")

endmodule
